[design/esc_pkg.sv]
// ----------------------------------------------------------------------------
// esc_pkg
// Shared types, constants and arithmetic helpers of the sensor compensation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package esc_pkg;

  localparam int AddrW       = 6;
  localparam int DataW       = 64;
  localparam int DivBits     = 64;
  localparam int FrontStages = 11;
  localparam int BackStages  = 6;

  localparam logic [2:0] RegTemp   = 3'd0;
  localparam logic [2:0] RegPressA = 3'd1;
  localparam logic [2:0] RegPressB = 3'd2;
  localparam logic [2:0] RegPressC = 3'd3;
  localparam logic [2:0] RegHum    = 3'd4;

  localparam logic [32:0] TempOfs   = 33'd128000;
  localparam logic [20:0] PressBase = 21'd1048576;
  localparam logic [63:0] PressMul  = 64'd3125;
  localparam logic [63:0] PressBias = 64'h0000_8000_0000_0000;
  localparam logic [31:0] HumOfs    = 32'd76800;
  localparam logic [31:0] HumMax    = 32'd419430400;
  localparam logic [16:0] HumMaxQ   = 17'd102400;
  localparam logic [31:0] HumRndA   = 32'd16384;
  localparam logic [31:0] HumAddB   = 32'd2097152;
  localparam logic [31:0] HumRndB   = 32'd8192;
  localparam logic [31:0] HumAddC   = 32'd32768;

  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
    logic [15:0] p1;
    logic [15:0] p2;
    logic [15:0] p3;
    logic [15:0] p4;
    logic [15:0] p5;
    logic [15:0] p6;
    logic [15:0] p7;
    logic [15:0] p8;
    logic [15:0] p9;
    logic [7:0]  h1;
    logic [15:0] h2;
    logic [7:0]  h3;
    logic [11:0] h4;
    logic [11:0] h5;
    logic [7:0]  h6;
  } esc_coef_t;

  typedef struct packed {
    logic [31:0] temp;
    logic [16:0] hum;
    logic        zero;
  } esc_side_t;

  typedef struct packed {
    esc_side_t   side;
    logic        neg;
    logic [30:0] mb;
    logic [63:0] mag;
  } esc_dvd_t;

  typedef struct packed {
    esc_side_t   side;
    logic        neg;
    logic [63:0] quo;
  } esc_quo_t;

  // partial products of a 64 x 64 product taken modulo 2^64
  typedef struct packed {
    logic [63:0] ll;
    logic [31:0] hx;
  } esc_pp_t;

  function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned n);
    logic signed [31:0] s;
    s = signed'(x);
    return s >>> n;
  endfunction

  function automatic logic [63:0] asr64(input logic [63:0] x, input int unsigned n);
    logic signed [63:0] s;
    s = signed'(x);
    return s >>> n;
  endfunction

  function automatic logic [31:0] sx32_16(input logic [15:0] x);
    return {{16{x[15]}}, x};
  endfunction

  function automatic logic [31:0] sx32_12(input logic [11:0] x);
    return {{20{x[11]}}, x};
  endfunction

  function automatic logic [31:0] sx32_8(input logic [7:0] x);
    return {{24{x[7]}}, x};
  endfunction

  function automatic logic [63:0] sx64_16(input logic [15:0] x);
    return {{48{x[15]}}, x};
  endfunction

  function automatic esc_pp_t pp_f(input logic [63:0] a, input logic [63:0] b);
    esc_pp_t     r;
    logic [31:0] x0;
    logic [31:0] x1;
    r.ll = a[31:0] * b[31:0];
    x0   = a[63:32] * b[31:0];
    x1   = a[31:0] * b[63:32];
    r.hx = x0 + x1;
    return r;
  endfunction

  function automatic logic [63:0] pp_sum(input esc_pp_t p);
    return p.ll + {p.hx, 32'd0};
  endfunction

endpackage

[design/esc_meas_if.sv]
// ----------------------------------------------------------------------------
// esc_meas_if
// Raw measurement channel: valid / ready with one raw sample set per word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface esc_meas_if;
  logic        valid;
  logic        ready;
  logic [19:0] raw_temp;
  logic [19:0] raw_press;
  logic [15:0] raw_hum;

  modport source(output valid, raw_temp, raw_press, raw_hum, input ready);
  modport sink(input valid, raw_temp, raw_press, raw_hum, output ready);
endinterface

[design/esc_res_if.sv]
// ----------------------------------------------------------------------------
// esc_res_if
// Compensated result channel: valid / ready with one result set per word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface esc_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] temp_centideg;
  logic [23:0] press_pascal;
  logic [16:0] hum_q10;

  modport source(output valid, temp_centideg, press_pascal, hum_q10, input ready);
  modport sink(input valid, temp_centideg, press_pascal, hum_q10, output ready);
endinterface

[design/esc_cfg.sv]
// ----------------------------------------------------------------------------
// esc_cfg
// APB register file holding the calibration words, decoded into fields.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module esc_cfg (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [esc_pkg::AddrW-1:0] paddr,
  input  logic [esc_pkg::DataW-1:0] pwdata,
  output logic [esc_pkg::DataW-1:0] prdata,
  output logic                     pready,
  output esc_pkg::esc_coef_t       coef_o
);

  logic [47:0] temp_q, temp_d;
  logic [47:0] pa_q, pa_d;
  logic [47:0] pb_q, pb_d;
  logic [47:0] pc_q, pc_d;
  logic [63:0] hum_q, hum_d;
  logic        wr_en;
  logic [2:0]  idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[esc_pkg::AddrW-1:3];

  always_comb begin
    temp_d = temp_q;
    pa_d   = pa_q;
    pb_d   = pb_q;
    pc_d   = pc_q;
    hum_d  = hum_q;
    if (wr_en) begin
      case (idx)
        esc_pkg::RegTemp:   temp_d = pwdata[47:0];
        esc_pkg::RegPressA: pa_d   = pwdata[47:0];
        esc_pkg::RegPressB: pb_d   = pwdata[47:0];
        esc_pkg::RegPressC: pc_d   = pwdata[47:0];
        esc_pkg::RegHum:    hum_d  = pwdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_q <= '0;
      pa_q   <= '0;
      pb_q   <= '0;
      pc_q   <= '0;
      hum_q  <= '0;
    end else begin
      temp_q <= temp_d;
      pa_q   <= pa_d;
      pb_q   <= pb_d;
      pc_q   <= pc_d;
      hum_q  <= hum_d;
    end
  end

  always_comb begin
    case (idx)
      esc_pkg::RegTemp:   prdata = {16'd0, temp_q};
      esc_pkg::RegPressA: prdata = {16'd0, pa_q};
      esc_pkg::RegPressB: prdata = {16'd0, pb_q};
      esc_pkg::RegPressC: prdata = {16'd0, pc_q};
      esc_pkg::RegHum:    prdata = hum_q;
      default:            prdata = '0;
    endcase
  end

  always_comb begin
    coef_o.t1 = temp_q[15:0];
    coef_o.t2 = temp_q[31:16];
    coef_o.t3 = temp_q[47:32];
    coef_o.p1 = pa_q[15:0];
    coef_o.p2 = pa_q[31:16];
    coef_o.p3 = pa_q[47:32];
    coef_o.p4 = pb_q[15:0];
    coef_o.p5 = pb_q[31:16];
    coef_o.p6 = pb_q[47:32];
    coef_o.p7 = pc_q[15:0];
    coef_o.p8 = pc_q[31:16];
    coef_o.p9 = pc_q[47:32];
    coef_o.h1 = hum_q[7:0];
    coef_o.h2 = hum_q[23:8];
    coef_o.h3 = hum_q[31:24];
    coef_o.h4 = hum_q[43:32];
    coef_o.h5 = hum_q[55:44];
    coef_o.h6 = hum_q[63:56];
  end

endmodule

[design/esc_front.sv]
// ----------------------------------------------------------------------------
// esc_front
// Temperature, humidity and pressure operand pipeline ahead of the divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module esc_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  esc_pkg::esc_coef_t coef_i,
  input  logic               valid_i,
  output logic               ready_o,
  input  logic [19:0]        raw_temp_i,
  input  logic [19:0]        raw_press_i,
  input  logic [15:0]        raw_hum_i,
  output logic               valid_o,
  input  logic               ready_i,
  output esc_pkg::esc_dvd_t  data_o
);

  localparam int N = esc_pkg::FrontStages;

  typedef struct packed {
    logic [31:0] m1;
    logic [31:0] dd;
    logic [19:0] ap;
    logic [15:0] ah;
  } s1_t;

  typedef struct packed {
    logic [31:0] v1;
    logic [31:0] m2;
    logic [19:0] ap;
    logic [15:0] ah;
  } s2_t;

  typedef struct packed {
    logic [31:0] tfine;
    logic [19:0] ap;
    logic [15:0] ah;
  } s3_t;

  typedef struct packed {
    logic [31:0] temp;
    logic [32:0] w1;
    logic [31:0] hv;
    logic [19:0] ap;
    logic [15:0] ah;
  } s4_t;

  typedef struct packed {
    logic [31:0] temp;
    logic [63:0] sq;
    logic [63:0] w1p5;
    logic [63:0] w1p2;
    logic [31:0] h5v;
    logic [31:0] vh6;
    logic [31:0] vh3;
    logic [19:0] ap;
    logic [15:0] ah;
  } s5_t;

  typedef struct packed {
    logic [31:0]      temp;
    esc_pkg::esc_pp_t pp6;
    esc_pkg::esc_pp_t pp3;
    logic [63:0]      w1p5;
    logic [63:0]      w1p2;
    logic [31:0]      ha;
    logic [31:0]      bb;
    logic [19:0]      ap;
  } s6_t;

  typedef struct packed {
    logic [31:0] temp;
    logic [63:0] w2;
    logic [63:0] w1y;
    logic [31:0] ha;
    logic [31:0] bh;
    logic [19:0] ap;
  } s7_t;

  typedef struct packed {
    logic [31:0]      temp;
    esc_pkg::esc_pp_t pp1;
    logic [63:0]      num0;
    logic [31:0]      av;
  } s8_t;

  typedef struct packed {
    logic [31:0]      temp;
    logic [31:0]      dvs;
    esc_pkg::esc_pp_t ppn;
    logic [31:0]      av;
    logic [31:0]      sq15;
  } s9_t;

  typedef struct packed {
    logic [31:0] temp;
    logic [63:0] num;
    logic [31:0] dvs;
    logic [31:0] av;
    logic [31:0] hx;
  } s10_t;

  logic [N:1]   v_q;
  logic [N+1:1] en;

  s1_t  s1_d, s1_q;
  s2_t  s2_d, s2_q;
  s3_t  s3_d, s3_q;
  s4_t  s4_d, s4_q;
  s5_t  s5_d, s5_q;
  s6_t  s6_d, s6_q;
  s7_t  s7_d, s7_q;
  s8_t  s8_d, s8_q;
  s9_t  s9_d, s9_q;
  s10_t s10_d, s10_q;
  esc_pkg::esc_dvd_t s11_d, s11_q;

  logic signed [65:0] sq_full;
  logic signed [48:0] w1p5_full;
  logic signed [48:0] w1p2_full;
  logic [20:0]        pdiff;
  logic [63:0]        prod1;
  logic [63:0]        dvs64;
  logic [31:0]        s15;
  logic [31:0]        hv2;

  // pipeline control, a stage moves when empty or when the next one moves
  assign en[N+1] = ready_i;
  for (genvar k = 1; k <= N; k++) begin : g_en
    assign en[k] = ~v_q[k] | en[k+1];
  end

  assign ready_o = en[1];
  assign valid_o = v_q[N];
  assign data_o  = s11_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= (en[N:1] & {v_q[N-1:1], valid_i}) | (~en[N:1] & v_q);
    end
  end

  // temperature
  always_comb begin
    s1_d.m1 = ({15'd0, raw_temp_i[19:3]} - {15'd0, coef_i.t1, 1'b0})
              * esc_pkg::sx32_16(coef_i.t2);
    s1_d.dd = ({16'd0, raw_temp_i[19:4]} - {16'd0, coef_i.t1})
              * ({16'd0, raw_temp_i[19:4]} - {16'd0, coef_i.t1});
    s1_d.ap = raw_press_i;
    s1_d.ah = raw_hum_i;

    s2_d.v1 = esc_pkg::asr32(s1_q.m1, 11);
    s2_d.m2 = esc_pkg::asr32(s1_q.dd, 12) * esc_pkg::sx32_16(coef_i.t3);
    s2_d.ap = s1_q.ap;
    s2_d.ah = s1_q.ah;

    s3_d.tfine = s2_q.v1 + esc_pkg::asr32(s2_q.m2, 14);
    s3_d.ap    = s2_q.ap;
    s3_d.ah    = s2_q.ah;

    s4_d.temp = esc_pkg::asr32(s3_q.tfine * 32'd5 + 32'd128, 8);
    s4_d.w1   = {s3_q.tfine[31], s3_q.tfine} - esc_pkg::TempOfs;
    s4_d.hv   = s3_q.tfine - esc_pkg::HumOfs;
    s4_d.ap   = s3_q.ap;
    s4_d.ah   = s3_q.ah;
  end

  assign sq_full   = $signed(s4_q.w1) * $signed(s4_q.w1);
  assign w1p5_full = $signed(s4_q.w1) * $signed(coef_i.p5);
  assign w1p2_full = $signed(s4_q.w1) * $signed(coef_i.p2);

  // products of the offset fine temperature
  always_comb begin
    s5_d.temp = s4_q.temp;
    s5_d.sq   = sq_full[63:0];
    s5_d.w1p5 = {{15{w1p5_full[48]}}, w1p5_full} << 17;
    s5_d.w1p2 = {{15{w1p2_full[48]}}, w1p2_full} << 12;
    s5_d.h5v  = esc_pkg::sx32_12(coef_i.h5) * s4_q.hv;
    s5_d.vh6  = s4_q.hv * esc_pkg::sx32_8(coef_i.h6);
    s5_d.vh3  = s4_q.hv * {24'd0, coef_i.h3};
    s5_d.ap   = s4_q.ap;
    s5_d.ah   = s4_q.ah;

    s6_d.temp = s5_q.temp;
    s6_d.pp6  = esc_pkg::pp_f(s5_q.sq, esc_pkg::sx64_16(coef_i.p6));
    s6_d.pp3  = esc_pkg::pp_f(s5_q.sq, esc_pkg::sx64_16(coef_i.p3));
    s6_d.w1p5 = s5_q.w1p5;
    s6_d.w1p2 = s5_q.w1p2;
    s6_d.ha   = esc_pkg::asr32(({16'd0, s5_q.ah} << 14)
                - (esc_pkg::sx32_12(coef_i.h4) << 20) - s5_q.h5v
                + esc_pkg::HumRndA, 15);
    s6_d.bb   = esc_pkg::asr32(s5_q.vh6, 10)
                * (esc_pkg::asr32(s5_q.vh3, 11) + esc_pkg::HumAddC);
    s6_d.ap   = s5_q.ap;

    s7_d.temp = s6_q.temp;
    s7_d.w2   = esc_pkg::pp_sum(s6_q.pp6) + s6_q.w1p5
                + (esc_pkg::sx64_16(coef_i.p4) << 35);
    s7_d.w1y  = esc_pkg::asr64(esc_pkg::pp_sum(s6_q.pp3), 8) + s6_q.w1p2
                + esc_pkg::PressBias;
    s7_d.ha   = s6_q.ha;
    s7_d.bh   = (esc_pkg::asr32(s6_q.bb, 10) + esc_pkg::HumAddB)
                * esc_pkg::sx32_16(coef_i.h2) + esc_pkg::HumRndB;
    s7_d.ap   = s6_q.ap;
  end

  assign pdiff = esc_pkg::PressBase - {1'b0, s7_q.ap};
  assign prod1 = esc_pkg::pp_sum(s8_q.pp1);
  assign dvs64 = esc_pkg::asr64(prod1, 33);
  assign s15   = esc_pkg::asr32(s8_q.av, 15);
  assign hv2   = s10_q.av - esc_pkg::asr32(s10_q.hx, 4);

  // dividend, divisor and the humidity tail
  always_comb begin
    s8_d.temp = s7_q.temp;
    s8_d.pp1  = esc_pkg::pp_f(s7_q.w1y, {48'd0, coef_i.p1});
    s8_d.num0 = ({43'd0, pdiff} << 31) - s7_q.w2;
    s8_d.av   = s7_q.ha * esc_pkg::asr32(s7_q.bh, 14);

    s9_d.temp = s8_q.temp;
    s9_d.dvs  = dvs64[31:0];
    s9_d.ppn  = esc_pkg::pp_f(s8_q.num0, esc_pkg::PressMul);
    s9_d.av   = s8_q.av;
    s9_d.sq15 = s15 * s15;

    s10_d.temp = s9_q.temp;
    s10_d.num  = esc_pkg::pp_sum(s9_q.ppn);
    s10_d.dvs  = s9_q.dvs;
    s10_d.av   = s9_q.av;
    s10_d.hx   = esc_pkg::asr32(s9_q.sq15, 7) * {24'd0, coef_i.h1};

    s11_d.side.temp = s10_q.temp;
    s11_d.side.zero = (s10_q.dvs == 32'd0);
    if (hv2[31]) begin
      s11_d.side.hum = '0;
    end else if (hv2 > esc_pkg::HumMax) begin
      s11_d.side.hum = esc_pkg::HumMaxQ;
    end else begin
      s11_d.side.hum = hv2[28:12];
    end
    s11_d.neg = s10_q.num[63] ^ s10_q.dvs[31];
    s11_d.mag = s10_q.num[63] ? (64'd0 - s10_q.num) : s10_q.num;
    s11_d.mb  = s10_q.dvs[31] ? 31'(32'd0 - s10_q.dvs) : s10_q.dvs[30:0];
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s1_q <= s1_d;
    end
    if (en[2]) begin
      s2_q <= s2_d;
    end
    if (en[3]) begin
      s3_q <= s3_d;
    end
    if (en[4]) begin
      s4_q <= s4_d;
    end
    if (en[5]) begin
      s5_q <= s5_d;
    end
    if (en[6]) begin
      s6_q <= s6_d;
    end
    if (en[7]) begin
      s7_q <= s7_d;
    end
    if (en[8]) begin
      s8_q <= s8_d;
    end
    if (en[9]) begin
      s9_q <= s9_d;
    end
    if (en[10]) begin
      s10_q <= s10_d;
    end
    if (en[11]) begin
      s11_q <= s11_d;
    end
  end

endmodule

[design/esc_div.sv]
// ----------------------------------------------------------------------------
// esc_div
// Pipelined unsigned 64 by 31 bit restoring divider, one quotient bit a stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module esc_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  esc_pkg::esc_dvd_t data_i,
  output logic              valid_o,
  input  logic              ready_i,
  output esc_pkg::esc_quo_t data_o
);

  localparam int N = esc_pkg::DivBits;

  typedef struct packed {
    esc_pkg::esc_side_t side;
    logic               neg;
    logic [30:0]        mb;
    logic [30:0]        rem;
    logic [63:0]        dq;
  } dstg_t;

  function automatic dstg_t div_step(input dstg_t x);
    dstg_t       r;
    logic [31:0] t;
    logic        ge;
    r    = x;
    t    = {x.rem, x.dq[63]};
    ge   = (t >= {1'b0, x.mb});
    r.rem = ge ? 31'(t - {1'b0, x.mb}) : t[30:0];
    r.dq  = {x.dq[62:0], ge};
    return r;
  endfunction

  logic [N:1]   v_q;
  logic [N+1:1] en;
  dstg_t        stg_in [N];
  dstg_t        stg_q  [N];

  assign en[N+1] = ready_i;
  for (genvar k = 1; k <= N; k++) begin : g_en
    assign en[k] = ~v_q[k] | en[k+1];
  end

  assign ready_o = en[1];
  assign valid_o = v_q[N];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= (en[N:1] & {v_q[N-1:1], valid_i}) | (~en[N:1] & v_q);
    end
  end

  assign stg_in[0] = '{side: data_i.side, neg: data_i.neg, mb: data_i.mb,
                       rem: '0, dq: data_i.mag};

  for (genvar k = 1; k < N; k++) begin : g_link
    assign stg_in[k] = stg_q[k-1];
  end

  for (genvar k = 0; k < N; k++) begin : g_stage
    always_ff @(posedge clk_i) begin
      if (en[k+1]) begin
        stg_q[k] <= div_step(stg_in[k]);
      end
    end
  end

  assign data_o = '{side: stg_q[N-1].side, neg: stg_q[N-1].neg, quo: stg_q[N-1].dq};

endmodule

[design/esc_back.sv]
// ----------------------------------------------------------------------------
// esc_back
// Pressure refinement after the division and the result output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module esc_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  esc_pkg::esc_coef_t coef_i,
  input  logic               valid_i,
  output logic               ready_o,
  input  esc_pkg::esc_quo_t  data_i,
  output logic               valid_o,
  input  logic               ready_i,
  output logic [31:0]        temp_o,
  output logic [23:0]        press_o,
  output logic [16:0]        hum_o
);

  localparam int N = esc_pkg::BackStages;

  typedef struct packed {
    esc_pkg::esc_side_t side;
    logic [63:0]        p;
  } b1_t;

  typedef struct packed {
    esc_pkg::esc_side_t side;
    logic [63:0]        p;
    logic [63:0]        s;
    esc_pkg::esc_pp_t   pps;
    esc_pkg::esc_pp_t   pp8;
  } b2_t;

  typedef struct packed {
    esc_pkg::esc_side_t side;
    logic [63:0]        p;
    logic [63:0]        s;
    logic [63:0]        ps9;
    logic [63:0]        p8p;
  } b3_t;

  typedef struct packed {
    esc_pkg::esc_side_t side;
    logic [63:0]        p;
    logic [63:0]        p8p;
    esc_pkg::esc_pp_t   ppq;
  } b4_t;

  typedef struct packed {
    esc_pkg::esc_side_t side;
    logic [63:0]        acc;
  } b5_t;

  typedef struct packed {
    logic [31:0] temp;
    logic [23:0] press;
    logic [16:0] hum;
  } b6_t;

  logic [N:1]   v_q;
  logic [N+1:1] en;

  b1_t b1_d, b1_q;
  b2_t b2_d, b2_q;
  b3_t b3_d, b3_q;
  b4_t b4_d, b4_q;
  b5_t b5_d, b5_q;
  b6_t b6_d, b6_q;

  logic [63:0] s_w;
  logic [63:0] pf;

  assign en[N+1] = ready_i;
  for (genvar k = 1; k <= N; k++) begin : g_en
    assign en[k] = ~v_q[k] | en[k+1];
  end

  assign ready_o = en[1];
  assign valid_o = v_q[N];
  assign temp_o  = b6_q.temp;
  assign press_o = b6_q.press;
  assign hum_o   = b6_q.hum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= (en[N:1] & {v_q[N-1:1], valid_i}) | (~en[N:1] & v_q);
    end
  end

  assign s_w = esc_pkg::asr64(b1_q.p, 13);
  assign pf  = esc_pkg::asr64(b5_q.acc, 8) + (esc_pkg::sx64_16(coef_i.p7) << 4);

  always_comb begin
    b1_d.side = data_i.side;
    b1_d.p    = data_i.neg ? (64'd0 - data_i.quo) : data_i.quo;

    b2_d.side = b1_q.side;
    b2_d.p    = b1_q.p;
    b2_d.s    = s_w;
    b2_d.pps  = esc_pkg::pp_f(s_w, esc_pkg::sx64_16(coef_i.p9));
    b2_d.pp8  = esc_pkg::pp_f(b1_q.p, esc_pkg::sx64_16(coef_i.p8));

    b3_d.side = b2_q.side;
    b3_d.p    = b2_q.p;
    b3_d.s    = b2_q.s;
    b3_d.ps9  = esc_pkg::pp_sum(b2_q.pps);
    b3_d.p8p  = esc_pkg::pp_sum(b2_q.pp8);

    b4_d.side = b3_q.side;
    b4_d.p    = b3_q.p;
    b4_d.p8p  = b3_q.p8p;
    b4_d.ppq  = esc_pkg::pp_f(b3_q.ps9, b3_q.s);

    b5_d.side = b4_q.side;
    b5_d.acc  = b4_q.p + esc_pkg::asr64(esc_pkg::pp_sum(b4_q.ppq), 25)
                + esc_pkg::asr64(b4_q.p8p, 19);

    b6_d.temp  = b5_q.side.temp;
    b6_d.hum   = b5_q.side.hum;
    b6_d.press = b5_q.side.zero ? 24'd0 : pf[31:8];
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      b1_q <= b1_d;
    end
    if (en[2]) begin
      b2_q <= b2_d;
    end
    if (en[3]) begin
      b3_q <= b3_d;
    end
    if (en[4]) begin
      b4_q <= b4_d;
    end
    if (en[5]) begin
      b5_q <= b5_d;
    end
    if (en[6]) begin
      b6_q <= b6_d;
    end
  end

endmodule

[design/env_sensor_compensation.sv]
// ----------------------------------------------------------------------------
// env_sensor_compensation
// Integer temperature, pressure and humidity compensation of raw sensor
// readings. One raw word is taken per clock while the pipe is not stalled and
// each gives one result word, in order: 11 stages of operand arithmetic, a
// 64-stage divider producing one quotient bit per stage, and 6 stages of
// pressure refinement ending in the output register. Every stage carries its
// own valid bit and holds when the next one is full and stalled, so the input
// keeps accepting until the whole pipe is full. Calibration registers sit on
// the APB port at byte address 8 * index; the user must write them only while
// no word is in flight, and the block itself does not enforce this.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module env_sensor_compensation (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [esc_pkg::AddrW-1:0] paddr,
  input  logic [esc_pkg::DataW-1:0] pwdata,
  output logic [esc_pkg::DataW-1:0] prdata,
  output logic                      pready,
  esc_meas_if.sink                  meas_i,
  esc_res_if.source                 res_o
);

  esc_pkg::esc_coef_t coef;
  esc_pkg::esc_dvd_t  dvd;
  esc_pkg::esc_quo_t  quo;
  logic               dvd_valid;
  logic               dvd_ready;
  logic               quo_valid;
  logic               quo_ready;

  esc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .coef_o  (coef)
  );

  esc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .coef_i      (coef),
    .valid_i     (meas_i.valid),
    .ready_o     (meas_i.ready),
    .raw_temp_i  (meas_i.raw_temp),
    .raw_press_i (meas_i.raw_press),
    .raw_hum_i   (meas_i.raw_hum),
    .valid_o     (dvd_valid),
    .ready_i     (dvd_ready),
    .data_o      (dvd)
  );

  esc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dvd_valid),
    .ready_o (dvd_ready),
    .data_i  (dvd),
    .valid_o (quo_valid),
    .ready_i (quo_ready),
    .data_o  (quo)
  );

  esc_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .coef_i  (coef),
    .valid_i (quo_valid),
    .ready_o (quo_ready),
    .data_i  (quo),
    .valid_o (res_o.valid),
    .ready_i (res_o.ready),
    .temp_o  (res_o.temp_centideg),
    .press_o (res_o.press_pascal),
    .hum_o   (res_o.hum_q10)
  );

endmodule

[tb/sv/tb_env_sensor_compensation.sv]
// ----------------------------------------------------------------------------
// tb_env_sensor_compensation
// Self-checking bench for the sensor compensation block. Calibration words are
// loaded over APB while idle, raw measurement words go through a table of
// directed cases and then random traffic; each result word is checked field
// by field against a given word (reset cases) or an in-bench integer predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_env_sensor_compensation;

  typedef struct packed {
    logic [31:0] temp;
    logic [23:0] press;
    logic [16:0] hum;
  } comp_res_t;

  typedef struct {
    logic [19:0] rt;
    logic [19:0] rp;
    logic [15:0] rh;
    logic        known;
    comp_res_t   res;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;
  logic psel, penable, pwrite;
  logic [esc_pkg::AddrW-1:0] paddr;
  logic [esc_pkg::DataW-1:0] pwdata;
  logic [esc_pkg::DataW-1:0] prdata;
  logic pready;

  esc_meas_if meas ();
  esc_res_if  res ();

  env_sensor_compensation uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .meas_i(meas.sink), .res_o(res.source)
  );

  logic [63:0] coef_temp, coef_pa, coef_pb, coef_pc, coef_hum;
  comp_res_t   expected_q[$];
  int          mismatches;
  int          cycles;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic logic [63:0] sx(input logic [63:0] v, input int w);
    logic [63:0] m;
    m = 64'd1 << (w - 1);
    v = v & ((m << 1) - 64'd1);
    return (v ^ m) - m;
  endfunction

  function automatic logic [31:0] sr32(input logic [31:0] x, input int n);
    logic signed [31:0] s;
    s = x;
    return s >>> n;
  endfunction

  function automatic logic [63:0] sr64(input logic [63:0] x, input int n);
    logic signed [63:0] s;
    s = x;
    return s >>> n;
  endfunction

  function automatic logic [63:0] quot64(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] ma, mb, q;
    ma = a[63] ? -a : a;
    mb = b[63] ? -b : b;
    q  = ma / mb;
    return (a[63] != b[63]) ? -q : q;
  endfunction

  function automatic comp_res_t compensate(input logic [19:0] rt, input logic [19:0] rp,
                                           input logic [15:0] rh);
    comp_res_t   r;
    logic [31:0] t1, t2, t3, v1, d, v2, tfine, h1, h2, h3, h4, h5, h6, v, a, b, s15;
    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, w1, w2, p, q, s;
    logic [31:0] press;
    t1 = {16'd0, coef_temp[15:0]};
    t2 = 32'(sx(coef_temp >> 16, 16));
    t3 = 32'(sx(coef_temp >> 32, 16));
    v1 = sr32((({12'd0, rt} >> 3) - (t1 << 1)) * t2, 11);
    d  = ({12'd0, rt} >> 4) - t1;
    v2 = sr32(sr32(d * d, 12) * t3, 14);
    tfine = v1 + v2;
    r.temp = sr32(tfine * 32'd5 + 32'd128, 8);

    p1 = {48'd0, coef_pa[15:0]};
    p2 = sx(coef_pa >> 16, 16);
    p3 = sx(coef_pa >> 32, 16);
    p4 = sx(coef_pb, 16);
    p5 = sx(coef_pb >> 16, 16);
    p6 = sx(coef_pb >> 32, 16);
    p7 = sx(coef_pc, 16);
    p8 = sx(coef_pc >> 16, 16);
    p9 = sx(coef_pc >> 32, 16);
    w1 = sx({32'd0, tfine}, 32) - 64'd128000;
    w2 = w1 * w1 * p6;
    w2 = w2 + ((w1 * p5) << 17);
    w2 = w2 + (p4 << 35);
    w1 = sr64(w1 * w1 * p3, 8) + ((w1 * p2) << 12);
    w1 = sr64(((64'd1 << 47) + w1) * p1, 33);
    press = 32'd0;
    if (w1 != 64'd0) begin
      p = 64'd1048576 - {44'd0, rp};
      p = quot64(((p << 31) - w2) * 64'd3125, w1);
      s = sr64(p, 13);
      q = sr64(p9 * s * s, 25);
      s = sr64(p8 * p, 19);
      p = sr64(p + q + s, 8) + (p7 << 4);
      press = p[31:0] >> 8;
    end
    r.press = press[23:0];

    h1 = {24'd0, coef_hum[7:0]};
    h2 = 32'(sx(coef_hum >> 8, 16));
    h3 = {24'd0, coef_hum[31:24]};
    h4 = 32'(sx(coef_hum >> 32, 12));
    h5 = 32'(sx(coef_hum >> 44, 12));
    h6 = 32'(sx(coef_hum >> 56, 8));
    v = tfine - 32'd76800;
    a = sr32(({16'd0, rh} << 14) - (h4 << 20) - (h5 * v) + 32'd16384, 15);
    b = sr32(v * h6, 10) * (sr32(v * h3, 11) + 32'd32768);
    b = sr32(b, 10) + 32'd2097152;
    b = sr32(b * h2 + 32'd8192, 14);
    v = a * b;
    s15 = sr32(v, 15);
    v = v - sr32(sr32(s15 * s15, 7) * h1, 4);
    if (v[31]) v = 32'd0;
    else if (v > 32'd419430400) v = 32'd419430400;
    r.hum = v[28:12];
    return r;
  endfunction

  task automatic write_coef(input logic [2:0] idx, input logic [63:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= esc_pkg::AddrW'({idx, 3'b000});
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      esc_pkg::RegTemp:   coef_temp = val & 64'h0000_FFFF_FFFF_FFFF;
      esc_pkg::RegPressA: coef_pa   = val & 64'h0000_FFFF_FFFF_FFFF;
      esc_pkg::RegPressB: coef_pb   = val & 64'h0000_FFFF_FFFF_FFFF;
      esc_pkg::RegPressC: coef_pc   = val & 64'h0000_FFFF_FFFF_FFFF;
      esc_pkg::RegHum:    coef_hum  = val;
      default: ;
    endcase
  endtask

  task automatic load_all(input logic [63:0] t, input logic [63:0] a, input logic [63:0] b,
                          input logic [63:0] c, input logic [63:0] h);
    write_coef(esc_pkg::RegTemp, t);
    write_coef(esc_pkg::RegPressA, a);
    write_coef(esc_pkg::RegPressB, b);
    write_coef(esc_pkg::RegPressC, c);
    write_coef(esc_pkg::RegHum, h);
  endtask

  task automatic send_word(input logic [19:0] rt, input logic [19:0] rp, input logic [15:0] rh,
                           input logic known, input comp_res_t given);
    int gap;
    gap = $urandom_range(0, 3);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      meas.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    meas.valid     <= 1'b1;
    meas.raw_temp  <= rt;
    meas.raw_press <= rp;
    meas.raw_hum   <= rh;
    @(posedge clk_i);
    while (!meas.ready) @(posedge clk_i);
    expected_q.push_back(known ? given : compensate(rt, rp, rh));
  endtask

  task automatic drain;
    meas.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic random_phase(input int n);
    for (int i = 0; i < n; i++) begin
      send_word(20'($urandom_range(0, 20'hFFFFF)), 20'($urandom_range(0, 20'hFFFFF)),
                16'($urandom_range(0, 16'hFFFF)), 1'b0, '0);
    end
  endtask

  // sink side: random stalls, compare against the oldest expectation
  initial begin
    int stall;
    comp_res_t exp_r;
    res.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = $urandom_range(0, 3);
      if (stall != 0) begin
        res.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res.ready <= 1'b1;
      @(posedge clk_i);
      while (!res.valid) @(posedge clk_i);
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word");
      end else begin
        exp_r = expected_q.pop_front();
        if (res.temp_centideg !== exp_r.temp || res.press_pascal !== exp_r.press ||
            res.hum_q10 !== exp_r.hum) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp t=%0h p=%0h h=%0h got t=%0h p=%0h h=%0h",
                     exp_r.temp, exp_r.press, exp_r.hum,
                     res.temp_centideg, res.press_pascal, res.hum_q10);
        end
      end
    end
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > 400000) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  stim_row_t rows[$];

  initial begin
    stim_row_t row;
    logic [63:0] typ_t, typ_a, typ_b, typ_c, typ_h;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    meas.valid = 1'b0; meas.raw_temp = '0; meas.raw_press = '0; meas.raw_hum = '0;
    coef_temp = '0; coef_pa = '0; coef_pb = '0; coef_pc = '0; coef_hum = '0;
    mismatches = 0;
    @(posedge rst_ni);
    @(posedge clk_i);

    // after reset all coefficients are zero: divisor zero, everything zero
    rows.push_back('{20'h00000, 20'h00000, 16'h0000, 1'b1, '{32'd0, 24'd0, 17'd0}});
    rows.push_back('{20'hFFFFF, 20'hFFFFF, 16'hFFFF, 1'b1, '{32'd0, 24'd0, 17'd0}});
    rows.push_back('{20'hAAAAA, 20'h55555, 16'h5A5A, 1'b1, '{32'd0, 24'd0, 17'd0}});
    foreach (rows[i]) send_word(rows[i].rt, rows[i].rp, rows[i].rh, rows[i].known, rows[i].res);
    drain();

    // typical calibration set
    typ_t = 64'({16'd50, 16'd26435, 16'd27504});
    typ_a = 64'({16'(-16'sd2375), 16'(-16'sd10685), 16'd36477});
    typ_b = 64'({16'd140, 16'(-16'sd7), 16'd2855});
    typ_c = 64'({16'd6000, 16'(-16'sd14600), 16'd15500});
    typ_h = {8'd30, 12'd0, 12'd330, 8'd0, 16'd366, 8'd75};
    load_all(typ_t, typ_a, typ_b, typ_c, typ_h);
    rows.delete();
    rows.push_back('{20'h00000, 20'h00000, 16'h0000, 1'b0, '0});
    rows.push_back('{20'hFFFFF, 20'hFFFFF, 16'hFFFF, 1'b0, '0});
    rows.push_back('{20'h7E000, 20'h5A000, 16'h6800, 1'b0, '0});
    rows.push_back('{20'h80000, 20'h00000, 16'hFFFF, 1'b0, '0});
    rows.push_back('{20'h00000, 20'hFFFFF, 16'h0000, 1'b0, '0});
    rows.push_back('{20'h55555, 20'hAAAAA, 16'hA5A5, 1'b0, '0});
    foreach (rows[i]) send_word(rows[i].rt, rows[i].rp, rows[i].rh, rows[i].known, rows[i].res);
    drain();

    // extremes: all ones, then sign-bit only signed and all-ones unsigned coefficients
    load_all(64'h0000_FFFF_FFFF_FFFF, 64'h0000_FFFF_FFFF_FFFF, 64'h0000_FFFF_FFFF_FFFF,
             64'h0000_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    rows.delete();
    rows.push_back('{20'h00000, 20'h00000, 16'h0000, 1'b0, '0});
    rows.push_back('{20'hFFFFF, 20'hFFFFF, 16'hFFFF, 1'b0, '0});
    rows.push_back('{20'h12345, 20'h6789A, 16'hBCDE, 1'b0, '0});
    foreach (rows[i]) send_word(rows[i].rt, rows[i].rp, rows[i].rh, rows[i].known, rows[i].res);
    drain();
    load_all(64'h0000_8000_8000_FFFF, 64'h0000_8000_8000_FFFF, 64'h0000_8000_8000_8000,
             64'h0000_8000_8000_8000, 64'h80_800_800_FF_8000_FF);
    rows.delete();
    rows.push_back('{20'h00000, 20'h00000, 16'h0000, 1'b0, '0});
    rows.push_back('{20'hFFFFF, 20'hFFFFF, 16'hFFFF, 1'b0, '0});
    rows.push_back('{20'h7FFFF, 20'h80000, 16'h8000, 1'b0, '0});
    foreach (rows[i]) send_word(rows[i].rt, rows[i].rp, rows[i].rh, rows[i].known, rows[i].res);
    drain();

    // mostly realistic calibration with random content, some fully random sets
    for (int ph = 0; ph < 8; ph++) begin
      if (ph % 3 == 2)
        load_all({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                 {$urandom, $urandom}, {$urandom, $urandom});
      else
        load_all(typ_t ^ 64'($urandom_range(0, 255)), typ_a ^ 64'($urandom_range(0, 255)),
                 typ_b ^ 64'($urandom_range(0, 255)), typ_c ^ 64'($urandom_range(0, 255)),
                 typ_h ^ 64'($urandom_range(0, 255)));
      random_phase(165);
      drain();
    end

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[env_sensor_compensation.f]
design/esc_pkg.sv
design/esc_meas_if.sv
design/esc_res_if.sv
design/esc_cfg.sv
design/esc_front.sv
design/esc_div.sv
design/esc_back.sv
design/env_sensor_compensation.sv
tb/sv/tb_env_sensor_compensation.sv
